// ----- hdl/piece_interval_search_macros.svh -----
// Assertion macros for the piece interval search block.
// No dependencies; included by piece_interval_search, which carries the assertions.
`ifndef PIECE_INTERVAL_SEARCH_MACROS_SVH
`define PIECE_INTERVAL_SEARCH_MACROS_SVH

`ifndef SYNTH

// Property must hold at every edge outside reset.
`define PIS_ASSERT(lbl, c, r, expr, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (expr)) else $error(msg);

// Same-cycle implication.
`define PIS_ASSERT_IMPL(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define PIS_ASSERT_NEXT(lbl, c, r, ante, cons, msg) \
    lbl: assert property (@(posedge c) disable iff (!r) (ante) |=> (cons)) else $error(msg);

`else

`define PIS_ASSERT(lbl, c, r, expr, msg)
`define PIS_ASSERT_IMPL(lbl, c, r, ante, cons, msg)
`define PIS_ASSERT_NEXT(lbl, c, r, ante, cons, msg)

`endif

`endif

// ----- hdl/pis_pkg.sv -----
// Shared types and constants for the piece interval search block.
// No dependencies.
package pis_pkg;

    localparam int MAX_PIECES_DEF = 16;
    localparam int TIME_W         = 32;
    localparam int SLOT_IN_W      = 5;
    localparam int CNT_W          = 5;
    localparam int IDX_W          = 4;
    localparam int STATUS_W       = 2;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    localparam logic [CNT_W-1:0] PIECE_COUNT_RST = CNT_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND = 2'd0,
        ST_BELOW = 2'd1,
        ST_ABOVE = 2'd2
    } status_t;

    // Compare flags of one breakpoint cell against the query time.
    typedef struct packed {
        logic lt;   // breakpoint < time
        logic gt;   // breakpoint > time
    } bp_flags_t;

    // Control carried along the search chain.
    typedef struct packed {
        logic    valid;
        status_t status;
    } srch_ctrl_t;

endpackage

// ----- hdl/pis_bp_cell.sv -----
// One breakpoint cell: holds one table slot and compares it with the query.
// Depends on pis_pkg.
module pis_bp_cell #(
    parameter int SLOT_ID = 0
) (
    input  logic                              clk,
    input  logic                              wr_en,
    input  logic [pis_pkg::SLOT_IN_W-1:0]     wr_slot,
    input  logic                              capture,
    input  logic signed [pis_pkg::TIME_W-1:0] time_value,
    output pis_pkg::bp_flags_t                flags
);
    import pis_pkg::*;

    logic signed [TIME_W-1:0] bp_reg;
    bp_flags_t                flags_reg;
    logic                     hit;

    assign hit   = wr_en && (32'(wr_slot) == SLOT_ID);
    assign flags = flags_reg;

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            bp_reg <= time_value;
        end
        if (capture)
        begin
            flags_reg.lt <= (bp_reg < time_value);
            flags_reg.gt <= (bp_reg > time_value);
        end
    end

endmodule

// ----- hdl/pis_step_cell.sv -----
// One binary search step: narrows [lo, hi] by one probe of the flag vector.
// Depends on pis_pkg.
module pis_step_cell #(
    parameter int SLOT_W = 5,
    parameter int NSLOT  = 17
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic [NSLOT-1:0]       lt_vec,
    input  pis_pkg::srch_ctrl_t    ctrl_in,
    input  logic [SLOT_W-1:0]      lo_in,
    input  logic [SLOT_W-1:0]      hi_in,
    output pis_pkg::srch_ctrl_t    ctrl_out,
    output logic [SLOT_W-1:0]      lo_out,
    output logic [SLOT_W-1:0]      hi_out
);
    import pis_pkg::*;

    srch_ctrl_t        ctrl_reg;
    logic [SLOT_W-1:0] lo_reg, lo_next;
    logic [SLOT_W-1:0] hi_reg, hi_next;
    logic [SLOT_W:0]   sum;
    logic [SLOT_W-1:0] mid;
    logic              open;

    always_comb
    begin
        sum     = {1'b0, lo_in} + {1'b0, hi_in};
        mid     = sum[SLOT_W:1];
        open    = {1'b0, hi_in} > ({1'b0, lo_in} + (SLOT_W+1)'(1));
        lo_next = lo_in;
        hi_next = hi_in;
        if (open)
        begin
            if (lt_vec[mid])
            begin
                lo_next = mid;
            end
            else
            begin
                hi_next = mid;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctrl_reg.valid  <= 1'b0;
            ctrl_reg.status <= ST_FOUND;
        end
        else if (en)
        begin
            ctrl_reg <= ctrl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lo_reg <= lo_next;
            hi_reg <= hi_next;
        end
    end

    assign ctrl_out = ctrl_reg;
    assign lo_out   = lo_reg;
    assign hi_out   = hi_reg;

endmodule

// ----- hdl/piece_interval_search.sv -----
// Piece interval search, top level: breakpoint cell row, search chain, output register.
// Depends on pis_pkg, pis_bp_cell, pis_step_cell and piece_interval_search_macros.svh.
//
// Keeps an ascending table of MAX_PIECES+1 signed Q16.16 breakpoints, one per
// cell, and maps a query time to the piece that holds it. A write item
// (operation = write) stores time_value into the given slot on the accepting
// edge and gives no result; slots above MAX_PIECES are dropped. A query item
// gives one result. On the accepting edge every breakpoint cell compares its
// slot with the query time in parallel and registers the flags. The next cycle
// decides below/above from slot 0 and slot piece_count, then the item walks
// down a chain of $clog2(MAX_PIECES) search cells, one binary-search probe per
// cell per cycle, and lands in the output register. A time equal to an inner
// breakpoint maps to the earlier piece. No new item is taken until the query
// has left the search chain, so the chain length sets when the next item can
// be taken. in_stall is high while a query is in the chain. The output register
// lets a new item be taken while a result waits for the downstream side.
// piece_count must be written through cfg_we/cfg_wdata only while the block is
// idle; the block itself does not enforce this. 0 counts as 1 and values above
// MAX_PIECES saturate. The table has no reset; reading an unwritten slot gives
// an undefined answer.
module piece_interval_search #(
    parameter int MAX_PIECES = pis_pkg::MAX_PIECES_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_we,
    input  logic [pis_pkg::CNT_W-1:0]           cfg_wdata,
    // input channel
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                operation,
    input  logic [pis_pkg::SLOT_IN_W-1:0]       slot,
    input  logic signed [pis_pkg::TIME_W-1:0]   time_value,
    // output channel
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [pis_pkg::IDX_W-1:0]           piece_index,
    output logic [pis_pkg::STATUS_W-1:0]        status
);
    import pis_pkg::*;

    `include "piece_interval_search_macros.svh"

    localparam int NSLOT  = MAX_PIECES + 1;
    localparam int SLOT_W = $clog2(NSLOT);
    localparam int STEPS  = (MAX_PIECES > 1) ? $clog2(MAX_PIECES) : 1;

    // configuration
    logic [CNT_W-1:0]  piece_count_reg;

    // handshake
    logic              in_accept;
    logic              wr_accept;
    logic              qry_accept;
    logic              busy;
    logic              adv;

    // per-query state
    logic              start_reg;
    logic [SLOT_W-1:0] n_reg, n_next;

    // cell row
    bp_flags_t         flags [NSLOT];
    logic [NSLOT-1:0]  lt_vec;

    // chain entry
    srch_ctrl_t        entry_ctrl;
    logic [SLOT_W-1:0] entry_hi;

    // search chain; index 0 is the entry, k+1 the output of step cell k
    srch_ctrl_t        chain_ctrl [STEPS+1];
    logic [SLOT_W-1:0] chain_lo   [STEPS+1];
    logic [SLOT_W-1:0] chain_hi   [STEPS+1];
    logic [STEPS:0]    chain_valid;

    // output register
    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  piece_index_reg;
    status_t           status_reg;
    logic              out_load;
    logic [31:0]       lo_wide;

    assign in_accept  = in_valid && !in_stall;
    assign wr_accept  = in_accept && (operation == OP_WRITE);
    assign qry_accept = in_accept && (operation == OP_QUERY);

    // Used piece count: zero reads as one, saturate at MAX_PIECES.
    always_comb
    begin
        if (piece_count_reg == '0)
        begin
            n_next = SLOT_W'(1);
        end
        else if (int'(piece_count_reg) > MAX_PIECES)
        begin
            n_next = SLOT_W'(MAX_PIECES);
        end
        else
        begin
            n_next = SLOT_W'(piece_count_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            piece_count_reg <= PIECE_COUNT_RST;
        end
        else if (cfg_we)
        begin
            piece_count_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg <= 1'b0;
        end
        else
        begin
            start_reg <= qry_accept;
        end
    end

    // n is only read while the query is in flight
    always_ff @(posedge clk)
    begin
        if (qry_accept)
        begin
            n_reg <= n_next;
        end
    end

    // Breakpoint cells
    for (genvar i = 0; i < NSLOT; i++)
    begin : g_cell
        pis_bp_cell #(
            .SLOT_ID (i)
        ) u_cell (
            .clk        (clk),
            .wr_en      (wr_accept),
            .wr_slot    (slot),
            .capture    (qry_accept),
            .time_value (time_value),
            .flags      (flags[i])
        );
        assign lt_vec[i] = flags[i].lt;
    end

    // Chain entry: range checks pick the status. Out-of-range items enter
    // with lo = 0, hi = 1 so no step moves them.
    always_comb
    begin
        entry_ctrl.valid = start_reg;
        if (flags[0].gt)
        begin
            entry_ctrl.status = ST_BELOW;
            entry_hi          = SLOT_W'(1);
        end
        else if (lt_vec[n_reg])
        begin
            entry_ctrl.status = ST_ABOVE;
            entry_hi          = SLOT_W'(1);
        end
        else
        begin
            entry_ctrl.status = ST_FOUND;
            entry_hi          = n_reg;
        end
    end

    assign chain_ctrl[0] = entry_ctrl;
    assign chain_lo[0]   = '0;
    assign chain_hi[0]   = entry_hi;

    for (genvar k = 0; k < STEPS; k++)
    begin : g_step
        pis_step_cell #(
            .SLOT_W (SLOT_W),
            .NSLOT  (NSLOT)
        ) u_step (
            .clk      (clk),
            .rst_n    (rst_n),
            .en       (adv),
            .lt_vec   (lt_vec),
            .ctrl_in  (chain_ctrl[k]),
            .lo_in    (chain_lo[k]),
            .hi_in    (chain_hi[k]),
            .ctrl_out (chain_ctrl[k+1]),
            .lo_out   (chain_lo[k+1]),
            .hi_out   (chain_hi[k+1])
        );
    end

    always_comb
    begin
        for (int k = 0; k <= STEPS; k++)
        begin
            chain_valid[k] = chain_ctrl[k].valid;
        end
    end

    assign busy     = |chain_valid;
    assign in_stall = busy;

    // Hold the chain only when a finished item meets a full, stalled output.
    assign out_load = chain_ctrl[STEPS].valid && (!out_valid_reg || !out_stall);
    assign adv      = !(chain_ctrl[STEPS].valid && out_valid_reg && out_stall);
    assign lo_wide  = 32'(chain_lo[STEPS]);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            piece_index_reg <= lo_wide[IDX_W-1:0];
            status_reg      <= chain_ctrl[STEPS].status;
        end
    end

    assign out_valid   = out_valid_reg;
    assign piece_index = piece_index_reg;
    assign status      = status_reg;

    // At most one query in the chain.
    `PIS_ASSERT(a_one_in_flight, clk, rst_n, $countones(chain_valid) <= 1, "two queries in chain")
    // Search has converged by the end of the chain.
    `PIS_ASSERT_IMPL(a_converged, clk, rst_n, chain_ctrl[STEPS].valid, chain_hi[STEPS] == chain_lo[STEPS] + SLOT_W'(1), "search not converged")
    // A found piece lies below the used count.
    `PIS_ASSERT_IMPL(a_in_range, clk, rst_n, chain_ctrl[STEPS].valid && chain_ctrl[STEPS].status == ST_FOUND, chain_lo[STEPS] < n_reg, "piece index out of range")
    // Range errors report piece 0.
    `PIS_ASSERT_NEXT(a_err_zero, clk, rst_n, out_load && chain_ctrl[STEPS].status != ST_FOUND, piece_index == '0, "error result with nonzero piece")

endmodule

// ----- verif/pis_lookup_checker.sv -----
// Scoreboard for the piece interval search block: predicts every lookup and checks each result.
// Depends on pis_pkg; instantiated next to the block by tb_piece_interval_search.
module pis_lookup_checker
    import pis_pkg::*;
#(
    parameter int MAX_PIECES = MAX_PIECES_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_we,
    input  logic [CNT_W-1:0]           cfg_wdata,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic                       operation,
    input  logic [SLOT_IN_W-1:0]       slot,
    input  logic signed [TIME_W-1:0]   time_value,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [IDX_W-1:0]           piece_index,
    input  logic [STATUS_W-1:0]        status,
    output int                         mismatch_count = 0,
    output int                         pending_results = 0,
    output int                         results_checked = 0
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [IDX_W-1:0] piece;
        status_t          stat;
    } lookup_t;

    logic signed [TIME_W-1:0] bp_table [0:MAX_PIECES];
    logic [CNT_W-1:0]         count_reg = PIECE_COUNT_RST;
    lookup_t                  lookups_due [$];
    int                       errs = 0;
    int                       seen = 0;

    // Binary search over the local breakpoint copy; equal inner times go to the earlier piece.
    function automatic lookup_t locate_piece(input logic signed [TIME_W-1:0] t);
        int unsigned n;
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        lookup_t     r;
        n = count_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_PIECES)
            n = MAX_PIECES;
        r.piece = '0;
        r.stat  = ST_FOUND;
        if (t < bp_table[0])
            r.stat = ST_BELOW;
        else if (t > bp_table[n])
            r.stat = ST_ABOVE;
        else
        begin
            lo = 0;
            hi = n;
            while (hi > lo + 1)
            begin
                mid = (lo + hi) >> 1;
                if (bp_table[mid] < t)
                    lo = mid;
                else
                    hi = mid;
            end
            r.piece = IDX_W'(lo);
        end
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        lookup_t want;
        if (!rst_n)
        begin
            count_reg = PIECE_COUNT_RST;
            lookups_due.delete();
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (lookups_due.size() == 0)
                begin
                    errs++;
                    $error("unexpected result: piece_index %0d, status %0d", piece_index, status);
                end
                else
                begin
                    want = lookups_due.pop_front();
                    seen++;
                    if (piece_index !== want.piece)
                    begin
                        errs++;
                        $error("piece_index: expected %0d, got %0d", want.piece, piece_index);
                    end
                    if (status !== want.stat)
                    begin
                        errs++;
                        $error("status: expected %0d, got %0d", want.stat, status);
                    end
                end
            end
            if (cfg_we)
                count_reg = cfg_wdata;
            if (in_valid && !in_stall)
            begin
                if (operation == OP_QUERY)
                    lookups_due.push_back(locate_piece(time_value));
                else if (slot <= MAX_PIECES)
                    bp_table[slot] = time_value;
            end
        end
        mismatch_count  <= errs;
        pending_results <= lookups_due.size();
        results_checked <= seen;
    end

endmodule

// ----- verif/tb_piece_interval_search.sv -----
// Testbench top for piece_interval_search: clock, reset, item stimulus and the verdict.
// Depends on pis_pkg, the block itself and pis_lookup_checker.
module tb_piece_interval_search;
    import pis_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET  = 1250;
    localparam int TAIL_ITEMS   = 150;   // last items run with no idling at all
    localparam int DRAIN_CYCLES = 10;    // extra settle time after the last result comes back

    logic                      clk;
    logic                      rst_n      = 1'b0;
    logic                      cfg_we     = 1'b0;
    logic [CNT_W-1:0]          cfg_wdata  = '0;
    logic                      in_valid   = 1'b0;
    logic                      in_stall;
    logic                      operation  = OP_WRITE;
    logic [SLOT_IN_W-1:0]      slot       = '0;
    logic signed [TIME_W-1:0]  time_value = '0;
    logic                      out_valid;
    logic                      out_stall  = 1'b0;
    logic [IDX_W-1:0]          piece_index;
    logic [STATUS_W-1:0]       status;

    int mismatch_count;
    int pending_results;
    int results_checked;

    // Stimulus-side copy of the table, only used to aim lookups at interesting times.
    int bp_copy [0:MAX_PIECES_DEF];
    int n_used     = 1;
    int n_items    = 0;
    int n_lookups  = 0;
    int n_writes   = 0;
    int n_settings = 0;
    int gap_pct    = 0;
    bit tail_quiet = 1'b0;
    int vals  [$];
    int order [$];

    piece_interval_search #(
        .MAX_PIECES (MAX_PIECES_DEF)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .operation   (operation),
        .slot        (slot),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .piece_index (piece_index),
        .status      (status)
    );

    pis_lookup_checker #(
        .MAX_PIECES (MAX_PIECES_DEF)
    ) i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .operation       (operation),
        .slot            (slot),
        .time_value      (time_value),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .piece_index     (piece_index),
        .status          (status),
        .mismatch_count  (mismatch_count),
        .pending_results (pending_results),
        .results_checked (results_checked)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Hard stop in case the handshake locks up.
    initial
    begin
        #2_000_000;
        $display("Mismatches found");
        $finish;
    end

    // Downstream back-pressure: random stall bursts, short and long free stretches,
    // and nothing at all once the tail of the run starts.
    initial
    begin
        int pick;
        wait (rst_n);
        forever
        begin
            pick = $urandom_range(0, 99);
            if (tail_quiet)
            begin
                out_stall <= 1'b0;
                @(posedge clk);
            end
            else if (pick < 30)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
            else if (pick < 40)
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(20, 60)) @(posedge clk);
            end
            else
            begin
                out_stall <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge clk);
            end
        end
    end

    // Present one item and hold it until the block takes it. Valid is left high on
    // return so back-to-back items follow with no idle gap between them.
    task automatic send_item(input logic op, input logic [SLOT_IN_W-1:0] sl,
                             input logic signed [TIME_W-1:0] t);
        if (!tail_quiet && $urandom_range(0, 99) < gap_pct)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid   <= 1'b1;
        operation  <= op;
        slot       <= sl;
        time_value <= t;
        do @(posedge clk); while (in_stall);
        if (op == OP_QUERY)
            n_lookups++;
        else if (sl <= MAX_PIECES_DEF)
        begin
            n_writes++;
            bp_copy[sl] = t;
        end
        // writes to slots past the table are dropped by the block, so not counted
        if (op == OP_QUERY || sl <= MAX_PIECES_DEF)
            n_items++;
        tail_quiet = (n_items >= ITEM_TARGET - TAIL_ITEMS);
    endtask

    // Stop sending and wait for every outstanding lookup to come back, then let the
    // chain settle.
    task automatic wait_until_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic set_piece_count(input logic [CNT_W-1:0] v);
        wait_until_idle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        // zero acts as one piece, anything past the table saturates
        n_used = (v == 0) ? 1 : (v > MAX_PIECES_DEF) ? MAX_PIECES_DEF : int'(v);
        n_settings++;
    endtask

    initial
    begin
        int phase;
        int j;
        int scale;
        int base;
        int pick;
        logic [CNT_W-1:0] cfg_pick;
        logic signed [TIME_W-1:0] qt;

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- directed part ----------------
        // Every slot gets written before any lookup: breakpoints -8.0 .. +8.0 in
        // steps of 1.0, so slot 8 is 0.0.
        for (int k = 0; k <= MAX_PIECES_DEF; k++)
            send_item(OP_WRITE, SLOT_IN_W'(k), (k - 8) * 32'sh0001_0000);
        // slot past the table: must not land anywhere
        send_item(OP_WRITE, SLOT_IN_W'(31), 32'sh7FFF_FFFF);

        // reset piece count of one: only slots 0 and 1 matter
        send_item(OP_QUERY, SLOT_IN_W'(0), -32'sd8 * 32'sh0001_0000);   // equal to first
        send_item(OP_QUERY, SLOT_IN_W'(31), -32'sd7 * 32'sh0001_0000);  // equal to last

        set_piece_count(CNT_W'(MAX_PIECES_DEF));
        send_item(OP_QUERY, SLOT_IN_W'(16), 32'sh8000_0000);    // most negative: below
        send_item(OP_QUERY, SLOT_IN_W'(5), 32'sh7FFF_FFFF);     // most positive: above
        send_item(OP_QUERY, SLOT_IN_W'(10), 32'sh0008_0000);    // last breakpoint: piece 15
        send_item(OP_QUERY, SLOT_IN_W'(21), 32'sh0000_0000);    // inner breakpoint: earlier piece
        send_item(OP_QUERY, SLOT_IN_W'(3), 32'sh0000_8000);     // 0.5: between slots 8 and 9

        // ---------------- random part ----------------
        // Each phase: drain, new piece count, reload the used slots (mostly ascending,
        // sometimes scrambled), then a burst of items, mostly lookups aimed around the breakpoints.
        phase = 0;
        while (n_items < ITEM_TARGET)
        begin
            case (phase)
                0: cfg_pick = CNT_W'(0);
                1: cfg_pick = CNT_W'(31);
                2: cfg_pick = CNT_W'(1);
                3: cfg_pick = CNT_W'(MAX_PIECES_DEF);
                default:
                    cfg_pick = ($urandom_range(0, 9) < 3) ? CNT_W'(MAX_PIECES_DEF)
                                                          : CNT_W'($urandom_range(0, 31));
            endcase
            set_piece_count(cfg_pick);

            case ($urandom_range(0, 2))
                0: gap_pct = 0;
                1: gap_pct = 15;
                default: gap_pct = 50;
            endcase

            // the narrowest scale gives duplicate breakpoints, the widest spans the full range
            vals.delete();
            order.delete();
            scale = $urandom_range(0, 2);
            base  = $urandom;
            for (int k = 0; k <= n_used; k++)
            begin
                case (scale)
                    0: vals.push_back($urandom);
                    1: vals.push_back(base + int'($urandom_range(0, 63)));
                    default: vals.push_back(base + int'($urandom_range(0, 32'h0010_0000)));
                endcase
                order.push_back(k);
            end
            if ($urandom_range(0, 99) < 80)
                vals.sort();
            order.shuffle();
            foreach (order[k])
            begin
                send_item(OP_WRITE, SLOT_IN_W'(order[k]), vals[order[k]]);
                if ($urandom_range(0, 9) == 0)
                    send_item(OP_WRITE, SLOT_IN_W'($urandom_range(17, 31)), $urandom);
            end

            repeat ($urandom_range(25, 60))
            begin
                pick = $urandom_range(0, 99);
                if (pick < 5)
                    send_item(OP_WRITE, SLOT_IN_W'($urandom_range(17, 31)), $urandom);
                else if (pick < 8)
                    send_item(OP_WRITE, SLOT_IN_W'($urandom_range(0, MAX_PIECES_DEF)), $urandom);
                else
                begin
                    j = $urandom_range(0, n_used);
                    case ($urandom_range(0, 9))
                        0, 1, 2: qt = bp_copy[j];
                        3: qt = bp_copy[j] + 1;
                        4: qt = bp_copy[j] - 1;
                        5: qt = (j < n_used)
                                ? int'((longint'(bp_copy[j]) + longint'(bp_copy[j + 1])) / 2)
                                : bp_copy[j];
                        6: qt = bp_copy[0] - int'($urandom_range(1, 4096));
                        7: qt = bp_copy[n_used] + int'($urandom_range(1, 4096));
                        8: qt = $urandom;
                        default: qt = $urandom_range(0, 1) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
                    endcase
                    send_item(OP_QUERY, SLOT_IN_W'($urandom_range(0, 31)), qt);
                end
            end
            phase++;
        end

        wait_until_idle();
        repeat (20) @(posedge clk);

        $display("Covered %0d items (%0d lookups, %0d slot writes) over %0d piece-count settings,",
                 n_items, n_lookups, n_writes, n_settings);
        $display("zero and saturating counts included; %0d results compared.", results_checked);
        if (mismatch_count == 0 && pending_results == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/pis_pkg.sv
hdl/pis_bp_cell.sv
hdl/pis_step_cell.sv
hdl/piece_interval_search.sv
verif/pis_lookup_checker.sv
verif/tb_piece_interval_search.sv
